// ===== hdl/sbmi_pkg.sv =====
`timescale 1ns / 1ps
package sbmi_pkg;

	localparam int CAPACITY_BITS_DEF = 65536;
	localparam int MAX_SETS_DEF      = 256;

	localparam int SET_COUNT_W  = 9;
	localparam int SET_ID_W     = 8;
	localparam int LOCATION_W   = 16;
	localparam int WORD_W       = 64;
	localparam int OFF_W        = 6;
	localparam int WORD_INDEX_W = 2;

	localparam logic [SET_COUNT_W-1:0] SET_COUNT_RST = 9'd256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_QRY,
		ST_QWAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_step;
		logic ins_wr;
		logic qry_rd;
		logic emit_step;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rd_last;
		logic emit_last;
		logic is_last;
	} sts_t;

endpackage

// ===== hdl/sbmi_ram.sv =====
`timescale 1ns / 1ps
module sbmi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/sbmi_ctrl.sv =====
`timescale 1ns / 1ps
module sbmi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          op,
	input  sbmi_pkg::sts_t sts,
	output sbmi_pkg::cmd_t cmd,
	output logic          busy
);

	import sbmi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (op == OP_INSERT) ? ST_INS_RD : ST_QRY;
				end
			end
			ST_INS_RD: begin
				state_d = ST_INS_WR;
			end
			ST_INS_WR: begin
				cmd.ins_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_QRY: begin
				cmd.qry_rd = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_QWAIT;
				end
			end
			ST_QWAIT: begin
				state_d = sts.is_last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== hdl/sbmi_dp.sv =====
`timescale 1ns / 1ps
module sbmi_dp #(
	parameter int CAPACITY_BITS = sbmi_pkg::CAPACITY_BITS_DEF,
	parameter int MAX_SETS      = sbmi_pkg::MAX_SETS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbmi_pkg::cmd_t                        cmd,
	output sbmi_pkg::sts_t                        sts,
	input  logic                                  op,
	input  logic [sbmi_pkg::SET_ID_W-1:0]         set_id,
	input  logic [sbmi_pkg::LOCATION_W-1:0]       location,
	input  logic                                  last_location,
	input  logic                                  cfg_valid,
	input  logic [sbmi_pkg::SET_COUNT_W-1:0]      set_count,
	output logic [sbmi_pkg::WORD_W-1:0]           match_word,
	output logic [sbmi_pkg::WORD_INDEX_W-1:0]     word_index,
	output logic                                  last_word,
	output logic                                  result_valid
);

	import sbmi_pkg::*;

	localparam int LOC_W     = $clog2(CAPACITY_BITS);
	localparam int AW        = LOC_W - OFF_W;
	localparam int DEPTH     = CAPACITY_BITS / WORD_W;
	localparam int ACC_WORDS = (MAX_SETS + WORD_W - 1) / WORD_W;
	localparam int CW        = $clog2(ACC_WORDS + 1);
	localparam int SW        = ($clog2(MAX_SETS + 1) > SET_COUNT_W) ?
		$clog2(MAX_SETS + 1) : SET_COUNT_W;
	localparam int RW        = SW + 1;
	localparam int EXT_W     = (LOC_W > LOCATION_W) ? LOC_W : LOCATION_W;

	logic [SET_COUNT_W-1:0] set_count_q;
	logic [SW-1:0]          sets;
	logic [SW-1:0]          words;
	logic [EXT_W-1:0]       loc_ext;
	logic [LOC_W-1:0]       loc_red;
	logic [LOC_W-1:0]       pos_q;
	logic                   last_q;
	logic [AW-1:0]          clr_q;
	logic [AW-1:0]          raddr;
	logic [AW-1:0]          waddr;
	logic                   we;
	logic [WORD_W-1:0]      wdata;
	logic [WORD_W-1:0]      rdata;
	logic [WORD_W-1:0]      prev_q;
	logic [CW-1:0]          rd_cnt_q;
	logic [CW-1:0]          idx_s1;
	logic                   valid_s1;
	logic [CW-1:0]          widx;
	logic [CW-1:0]          em_q;
	logic [WORD_W-1:0]      acc_q [ACC_WORDS];
	logic [WORD_W-1:0]      acc_rd;
	logic [2*WORD_W-1:0]    pair;
	logic [WORD_W-1:0]      win;
	logic [WORD_W-1:0]      match_word_q;
	logic [WORD_INDEX_W-1:0] word_index_q;
	logic                   last_word_q;
	logic                   result_valid_q;

	// valid bits of word w of a window of s sets
	function automatic logic [WORD_W-1:0] word_mask(input logic [SW-1:0] s,
		input logic [CW-1:0] w);
		logic [RW-1:0] rem;
		logic [WORD_W-1:0] m;
		rem = {1'b0, s} - RW'({w, {OFF_W{1'b0}}});
		if (rem >= RW'(WORD_W)) begin
			m = '1;
		end else begin
			m = ~({WORD_W{1'b1}} << rem[OFF_W-1:0]);
		end
		return m;
	endfunction

	always_comb begin
		if (set_count_q == '0) begin
			sets = SW'(1);
		end else if (SW'(set_count_q) > SW'(MAX_SETS)) begin
			sets = SW'(MAX_SETS);
		end else begin
			sets = SW'(set_count_q);
		end
	end

	assign words   = SW'(({1'b0, sets} + RW'(WORD_W - 1)) >> OFF_W);
	assign loc_ext = EXT_W'(location);
	assign loc_red = loc_ext[LOC_W-1:0];

	assign sts.clr_last  = &clr_q;
	assign sts.rd_last   = (SW'(rd_cnt_q) == words);
	assign sts.emit_last = ((SW'(em_q) + SW'(1)) == words);
	assign sts.is_last   = last_q;

	assign raddr = cmd.qry_rd ? (pos_q[LOC_W-1:OFF_W] + AW'(rd_cnt_q)) :
		pos_q[LOC_W-1:OFF_W];
	assign we    = cmd.clr_step | cmd.ins_wr;
	assign waddr = cmd.clr_step ? clr_q : pos_q[LOC_W-1:OFF_W];
	assign wdata = cmd.clr_step ? '0 :
		(rdata | (WORD_W'(1) << pos_q[OFF_W-1:0]));

	sbmi_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// window word = 64 bits from the store word pair, starting at the bit offset
	assign widx = idx_s1 - CW'(1);
	assign pair = {rdata, prev_q};
	assign win  = WORD_W'(pair >> pos_q[OFF_W-1:0]);

	always_comb begin
		acc_rd = '0;
		for (int i = 0; i < ACC_WORDS; i++) begin
			if (CW'(i) == em_q) begin
				acc_rd = acc_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count_q    <= SET_COUNT_RST;
			clr_q          <= '0;
			rd_cnt_q       <= '0;
			idx_s1         <= '0;
			valid_s1       <= 1'b0;
			em_q           <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < ACC_WORDS; i++) begin
				acc_q[i] <= '1;
			end
		end else begin
			if (cfg_valid) begin
				set_count_q <= set_count;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.load) begin
				rd_cnt_q <= '0;
			end else if (cmd.qry_rd) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			valid_s1 <= cmd.qry_rd;
			idx_s1   <= rd_cnt_q;
			if (cmd.load) begin
				em_q <= '0;
			end else if (cmd.emit_step) begin
				em_q <= em_q + CW'(1);
			end
			result_valid_q <= cmd.emit_step;
			if (cmd.emit_step && sts.emit_last) begin
				for (int i = 0; i < ACC_WORDS; i++) begin
					acc_q[i] <= '1;
				end
			end else if (valid_s1 && (idx_s1 != '0)) begin
				for (int i = 0; i < ACC_WORDS; i++) begin
					if (CW'(i) == widx) begin
						acc_q[i] <= acc_q[i] & win & word_mask(sets, widx);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= (op == OP_INSERT) ? (loc_red + LOC_W'(set_id)) : loc_red;
			last_q <= last_location;
		end
		if (valid_s1) begin
			prev_q <= rdata;
		end
		if (cmd.emit_step) begin
			match_word_q <= acc_rd & word_mask(sets, em_q);
			word_index_q <= WORD_INDEX_W'(em_q);
			last_word_q  <= sts.emit_last;
		end
	end

	assign match_word   = match_word_q;
	assign word_index   = word_index_q;
	assign last_word    = last_word_q;
	assign result_valid = result_valid_q;

endmodule

// ===== hdl/shifted_bloom_multiset_index.sv =====
`timescale 1ns / 1ps
// Shifted Bloom multiset index: one shared bit store for many sets.
// Command channel: an item (op, set_id, location, last_location) is taken
// on a clock edge with start high and busy low. Insert sets store bit
// (location + set_id) mod CAPACITY_BITS; query ANDs the set_count-bit window
// at location into the per-set accumulator.
// Config channel: cfg_valid/cfg_ready with set_count; cfg_ready is always high.
// Results: on the last query location, ceil(sets/64) words are driven, one per
// cycle, each marked by result_valid for a single cycle; the receiver cannot
// stall, so words are never held. The accumulator returns to all ones.
// Insert is a read-modify-write on the store RAM port: a read state, then a write.
// Query reads ceil(sets/64) + 1 store words, one per cycle; a last query then
// drives its result words. The first word is registered out of the emit state,
// which follows the query reads and the wait state.
// Reset: the store is cleared by a sweep over its CAPACITY_BITS/64 words
// (1024 by default) with busy high; set_count resets to 256.
module shifted_bloom_multiset_index #(
	parameter int CAPACITY_BITS = sbmi_pkg::CAPACITY_BITS_DEF,
	parameter int MAX_SETS      = sbmi_pkg::MAX_SETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [sbmi_pkg::SET_ID_W-1:0]     set_id,
	input  logic [sbmi_pkg::LOCATION_W-1:0]   location,
	input  logic                              last_location,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbmi_pkg::SET_COUNT_W-1:0]  set_count,
	output logic                              result_valid,
	output logic [sbmi_pkg::WORD_W-1:0]       match_word,
	output logic [sbmi_pkg::WORD_INDEX_W-1:0] word_index,
	output logic                              last_word
);

	import sbmi_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sbmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sbmi_dp #(
		.CAPACITY_BITS (CAPACITY_BITS),
		.MAX_SETS      (MAX_SETS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.set_id        (set_id),
		.location      (location),
		.last_location (last_location),
		.cfg_valid     (cfg_valid),
		.set_count     (set_count),
		.match_word    (match_word),
		.word_index    (word_index),
		.last_word     (last_word),
		.result_valid  (result_valid)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after an accepted item");

	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !$past(result_valid)) |-> (word_index == '0))
		else $error("first membership word not at index zero");

	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_word) |=>
		(result_valid && (word_index == $past(word_index) + 2'd1)))
		else $error("membership words not contiguous");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_word) |=> !result_valid)
		else $error("word follows the last word of a query");

endmodule
